### rtl/json_byte_tokenizer_top_assert.svh
// Assertion macros for the JSON byte tokenizer.
// Expects clk and rst_n in the scope of each use.
`ifndef JSON_BYTE_TOKENIZER_TOP_ASSERT_SVH
`define JSON_BYTE_TOKENIZER_TOP_ASSERT_SVH

// hold prop on every clock edge outside reset
`define JBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// hold cons on the edge after ante
`define JBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/jbt_pkg.sv
// Package for the JSON byte tokenizer: token and error codes, lexer modes,
// result word layout and character tables. No dependencies.
package jbt_pkg;

  typedef enum logic [3:0] {
    TOK_OBJ_BEGIN = 4'd0,
    TOK_OBJ_END   = 4'd1,
    TOK_ARR_BEGIN = 4'd2,
    TOK_ARR_END   = 4'd3,
    TOK_NUMBER    = 4'd4,
    TOK_STRING    = 4'd5,
    TOK_TRUE      = 4'd6,
    TOK_FALSE     = 4'd7,
    TOK_NULL      = 4'd8
  } tok_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_UNEXP_END  = 3'd1,
    ERR_UNEXP_CHAR = 3'd2,
    ERR_LIT_MISM   = 3'd3,
    ERR_BAD_ESC    = 3'd4,
    ERR_UNTERM     = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NUMBER  = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_ESCAPE  = 3'd3,
    MODE_UNICODE = 3'd4,
    MODE_LITERAL = 3'd5
  } mode_t;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  localparam int QDEPTH = 3;

  typedef struct packed {
    tok_t       tok_kind;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       token_end;
    err_t       error_code;
    logic       last;
  } res_t;

  localparam res_t RES_NONE = '{tok_kind: TOK_OBJ_BEGIN, data_valid: 1'b0,
                                data_byte: 8'h00, token_end: 1'b0,
                                error_code: ERR_NONE, last: 1'b0};

  typedef struct packed {
    logic       emit;
    res_t       res;
    logic       to_string;
    logic       to_number;
    logic       to_literal;
    logic [1:0] kind;
  } idle_t;

  typedef struct packed {
    logic       known;
    logic [7:0] val;
  } esc_t;

  function automatic res_t mk_res(tok_t t, logic dv, logic [7:0] b, logic e, err_t err);
    res_t r;
    r            = RES_NONE;
    r.tok_kind   = t;
    r.data_valid = dv;
    r.data_byte  = dv ? b : 8'h00;
    r.token_end  = e;
    r.error_code = err;
    return r;
  endfunction

  function automatic logic is_num_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || c == "-" || c == "+" || c == "." ||
           c == "e" || c == "E";
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] kind, logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case ({kind, pos})
      {LIT_TRUE, 3'd0}:  ch = "t";
      {LIT_TRUE, 3'd1}:  ch = "r";
      {LIT_TRUE, 3'd2}:  ch = "u";
      {LIT_TRUE, 3'd3}:  ch = "e";
      {LIT_FALSE, 3'd0}: ch = "f";
      {LIT_FALSE, 3'd1}: ch = "a";
      {LIT_FALSE, 3'd2}: ch = "l";
      {LIT_FALSE, 3'd3}: ch = "s";
      {LIT_FALSE, 3'd4}: ch = "e";
      default: begin
        if (kind[1]) begin
          case (pos)
            3'd0:    ch = "n";
            3'd1:    ch = "u";
            3'd2:    ch = "l";
            3'd3:    ch = "l";
            default: ch = 8'h00;
          endcase
        end
      end
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_last_pos(logic [1:0] kind);
    return (kind == LIT_FALSE) ? 3'd4 : 3'd3;
  endfunction

  function automatic tok_t lit_tok(logic [1:0] kind);
    tok_t t;
    unique case (kind)
      LIT_TRUE:  t = TOK_TRUE;
      LIT_FALSE: t = TOK_FALSE;
      default:   t = TOK_NULL;
    endcase
    return t;
  endfunction

  function automatic esc_t esc_map(logic [7:0] c);
    esc_t e;
    e.known = 1'b1;
    e.val   = c;
    case (c)
      "\"", "\\", "/": e.val = c;
      "b":             e.val = 8'h08;
      "f":             e.val = 8'h0C;
      "n":             e.val = 8'h0A;
      "r":             e.val = 8'h0D;
      "t":             e.val = 8'h09;
      default: begin
        e.known = 1'b0;
        e.val   = 8'h00;
      end
    endcase
    return e;
  endfunction

endpackage

### rtl/json_byte_tokenizer_top.sv
// JSON byte tokenizer top level: input register, lexer, result queue.
// Depends on jbt_pkg and json_byte_tokenizer_top_assert.svh.
//
//  channel | ports                                           | direction
//  in      | in_valid in_ready in_data_byte in_end_of_input   | byte in
//  out     | out_valid out_ready out_tok_kind ... out_last    | result out
//
// One byte per clock while out_ready stays high and each byte gives at most one
// result; a byte giving two results holds the input back while the single
// result port drains the three-entry result queue. out_valid rises once the
// byte has passed the input register and been written into the result queue.
// Synchronous reset clears the lexer mode, literal and escape counters and
// all valid flags. An output stall fills the queue, then holds the input.
module json_byte_tokenizer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_tok_kind,
  output logic       out_data_valid,
  output logic [7:0] out_data_byte_res,
  output logic       out_token_end,
  output logic [2:0] out_error_code,
  output logic       out_last
);

  logic       s1_v_r, s1_v_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_eoi_r;
  logic       adv;

  jbt_pkg::mode_t mode_r, mode_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       mis_r, mis_nxt;
  logic [1:0] uni_r, uni_nxt;

  jbt_pkg::res_t  q_r [jbt_pkg::QDEPTH];
  jbt_pkg::res_t  q_nxt [jbt_pkg::QDEPTH];
  logic [1:0]     q_cnt_r, q_cnt_nxt;
  logic [1:0]     base_idx;
  logic           pop;

  jbt_pkg::idle_t idl;
  jbt_pkg::esc_t  esc;
  jbt_pkg::res_t  res0, res1;
  logic [1:0]     n_res;
  logic [7:0]     c;
  logic           lit_mis_now;
  logic           lit_done;

  assign c           = s1_byte_r;
  assign adv         = s1_v_r && (q_cnt_r <= 2'd1);
  assign in_ready    = !s1_v_r || adv;
  assign s1_v_nxt    = (in_valid && in_ready) || (s1_v_r && !adv);
  assign esc         = jbt_pkg::esc_map(c);
  assign lit_mis_now = mis_r || (c != jbt_pkg::lit_char(kind_r, pos_r));
  assign lit_done    = pos_r >= jbt_pkg::lit_last_pos(kind_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_eoi_r  <= in_end_of_input;
    end
  end

  // idle decode of the current byte
  always_comb begin
    idl            = '0;
    idl.res        = jbt_pkg::RES_NONE;
    case (c)
      "{": begin
        idl.emit = 1'b1;
        idl.res  = jbt_pkg::mk_res(jbt_pkg::TOK_OBJ_BEGIN, 1'b0, 8'h00, 1'b1,
                                   jbt_pkg::ERR_NONE);
      end
      "}": begin
        idl.emit = 1'b1;
        idl.res  = jbt_pkg::mk_res(jbt_pkg::TOK_OBJ_END, 1'b0, 8'h00, 1'b1,
                                   jbt_pkg::ERR_NONE);
      end
      "[": begin
        idl.emit = 1'b1;
        idl.res  = jbt_pkg::mk_res(jbt_pkg::TOK_ARR_BEGIN, 1'b0, 8'h00, 1'b1,
                                   jbt_pkg::ERR_NONE);
      end
      "]": begin
        idl.emit = 1'b1;
        idl.res  = jbt_pkg::mk_res(jbt_pkg::TOK_ARR_END, 1'b0, 8'h00, 1'b1,
                                   jbt_pkg::ERR_NONE);
      end
      ":", ",", " ", 8'h0A, 8'h0D, 8'h09: idl.emit = 1'b0;
      "\"": idl.to_string = 1'b1;
      "t": begin
        idl.to_literal = 1'b1;
        idl.kind       = jbt_pkg::LIT_TRUE;
      end
      "f": begin
        idl.to_literal = 1'b1;
        idl.kind       = jbt_pkg::LIT_FALSE;
      end
      "n": begin
        idl.to_literal = 1'b1;
        idl.kind       = jbt_pkg::LIT_NULL;
      end
      8'h00: begin
        idl.emit = 1'b1;
        idl.res  = jbt_pkg::mk_res(jbt_pkg::TOK_OBJ_BEGIN, 1'b0, 8'h00, 1'b0,
                                   jbt_pkg::ERR_UNEXP_END);
      end
      default: begin
        idl.emit = 1'b1;
        if (c == "-" || (c >= "0" && c <= "9")) begin
          idl.to_number = 1'b1;
          idl.res       = jbt_pkg::mk_res(jbt_pkg::TOK_NUMBER, 1'b1, c, 1'b0,
                                          jbt_pkg::ERR_NONE);
        end else begin
          idl.res = jbt_pkg::mk_res(jbt_pkg::TOK_OBJ_BEGIN, 1'b0, 8'h00, 1'b0,
                                    jbt_pkg::ERR_UNEXP_CHAR);
        end
      end
    endcase
  end

  // next lexer state
  always_comb begin
    mode_nxt = mode_r;
    kind_nxt = kind_r;
    pos_nxt  = pos_r;
    mis_nxt  = mis_r;
    uni_nxt  = uni_r;
    if (s1_eoi_r) begin
      mode_nxt = jbt_pkg::MODE_IDLE;
    end else begin
      unique case (mode_r)
        jbt_pkg::MODE_STRING: begin
          if (c == "\"" || c == 8'h00) begin
            mode_nxt = jbt_pkg::MODE_IDLE;
          end else if (c == "\\") begin
            mode_nxt = jbt_pkg::MODE_ESCAPE;
          end
        end
        jbt_pkg::MODE_ESCAPE: begin
          if (c == "u") begin
            mode_nxt = jbt_pkg::MODE_UNICODE;
            uni_nxt  = 2'd0;
          end else if (esc.known) begin
            mode_nxt = jbt_pkg::MODE_STRING;
          end else begin
            mode_nxt = jbt_pkg::MODE_IDLE;
          end
        end
        jbt_pkg::MODE_UNICODE: begin
          uni_nxt = uni_r + 2'd1;
          if (uni_r == 2'd3) begin
            mode_nxt = jbt_pkg::MODE_STRING;
          end
        end
        jbt_pkg::MODE_LITERAL: begin
          if (lit_done) begin
            mode_nxt = jbt_pkg::MODE_IDLE;
            pos_nxt  = 3'd0;
            mis_nxt  = 1'b0;
          end else begin
            pos_nxt = pos_r + 3'd1;
            mis_nxt = lit_mis_now;
          end
        end
        default: begin
          if (mode_r != jbt_pkg::MODE_NUMBER || !jbt_pkg::is_num_char(c)) begin
            mode_nxt = jbt_pkg::MODE_IDLE;
            if (idl.to_string) begin
              mode_nxt = jbt_pkg::MODE_STRING;
            end else if (idl.to_number) begin
              mode_nxt = jbt_pkg::MODE_NUMBER;
            end else if (idl.to_literal) begin
              mode_nxt = jbt_pkg::MODE_LITERAL;
              kind_nxt = idl.kind;
              pos_nxt  = 3'd1;
              mis_nxt  = 1'b0;
            end
          end
        end
      endcase
    end
  end

  // results of the current byte
  always_comb begin
    res0  = jbt_pkg::RES_NONE;
    res1  = jbt_pkg::RES_NONE;
    n_res = 2'd0;
    if (s1_eoi_r) begin
      unique case (mode_r)
        jbt_pkg::MODE_NUMBER: begin
          n_res = 2'd1;
          res0  = jbt_pkg::mk_res(jbt_pkg::TOK_NUMBER, 1'b0, 8'h00, 1'b1,
                                  jbt_pkg::ERR_UNEXP_END);
        end
        jbt_pkg::MODE_STRING, jbt_pkg::MODE_ESCAPE, jbt_pkg::MODE_UNICODE: begin
          n_res = 2'd1;
          res0  = jbt_pkg::mk_res(jbt_pkg::TOK_STRING, 1'b0, 8'h00, 1'b1,
                                  jbt_pkg::ERR_UNTERM);
        end
        jbt_pkg::MODE_LITERAL: begin
          n_res = 2'd1;
          res0  = jbt_pkg::mk_res(jbt_pkg::lit_tok(kind_r), 1'b0, 8'h00, 1'b1,
                                  jbt_pkg::ERR_UNEXP_END);
        end
        default: n_res = 2'd0;
      endcase
    end else begin
      unique case (mode_r)
        jbt_pkg::MODE_NUMBER: begin
          if (jbt_pkg::is_num_char(c)) begin
            n_res = 2'd1;
            res0  = jbt_pkg::mk_res(jbt_pkg::TOK_NUMBER, 1'b1, c, 1'b0,
                                    jbt_pkg::ERR_NONE);
          end else begin
            res0  = jbt_pkg::mk_res(jbt_pkg::TOK_NUMBER, 1'b0, 8'h00, 1'b1,
                                    jbt_pkg::ERR_NONE);
            res1  = idl.res;
            n_res = idl.emit ? 2'd2 : 2'd1;
          end
        end
        jbt_pkg::MODE_STRING: begin
          if (c == "\"") begin
            n_res = 2'd1;
            res0  = jbt_pkg::mk_res(jbt_pkg::TOK_STRING, 1'b0, 8'h00, 1'b1,
                                    jbt_pkg::ERR_NONE);
          end else if (c == 8'h00) begin
            n_res = 2'd1;
            res0  = jbt_pkg::mk_res(jbt_pkg::TOK_STRING, 1'b0, 8'h00, 1'b1,
                                    jbt_pkg::ERR_UNTERM);
          end else if (c != "\\") begin
            n_res = 2'd1;
            res0  = jbt_pkg::mk_res(jbt_pkg::TOK_STRING, 1'b1, c, 1'b0,
                                    jbt_pkg::ERR_NONE);
          end
        end
        jbt_pkg::MODE_ESCAPE: begin
          if (c != "u") begin
            n_res = 2'd1;
            if (esc.known) begin
              res0 = jbt_pkg::mk_res(jbt_pkg::TOK_STRING, 1'b1, esc.val, 1'b0,
                                     jbt_pkg::ERR_NONE);
            end else begin
              res0 = jbt_pkg::mk_res(jbt_pkg::TOK_STRING, 1'b0, 8'h00, 1'b1,
                                     jbt_pkg::ERR_BAD_ESC);
            end
          end
        end
        jbt_pkg::MODE_UNICODE: n_res = 2'd0;
        jbt_pkg::MODE_LITERAL: begin
          if (lit_done) begin
            n_res = 2'd1;
            res0  = jbt_pkg::mk_res(jbt_pkg::lit_tok(kind_r), 1'b0, 8'h00, 1'b1,
                                    lit_mis_now ? jbt_pkg::ERR_LIT_MISM
                                                : jbt_pkg::ERR_NONE);
          end
        end
        default: begin
          res0  = idl.res;
          n_res = idl.emit ? 2'd1 : 2'd0;
        end
      endcase
    end
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jbt_pkg::MODE_IDLE;
      kind_r <= 2'd0;
      pos_r  <= 3'd0;
      mis_r  <= 1'b0;
      uni_r  <= 2'd0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      kind_r <= kind_nxt;
      pos_r  <= pos_nxt;
      mis_r  <= mis_nxt;
      uni_r  <= uni_nxt;
    end
  end

  // result queue: head at entry 0, shift on pop, append behind the tail
  assign pop      = (q_cnt_r != 2'd0) && out_ready;
  assign base_idx = q_cnt_r - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < jbt_pkg::QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
      if (pop && i < jbt_pkg::QDEPTH - 1) begin
        q_nxt[i] = q_r[i + 1];
      end
      if (adv && n_res != 2'd0 && base_idx == 2'(i)) begin
        q_nxt[i] = res0;
      end
      if (adv && n_res == 2'd2 && base_idx + 2'd1 == 2'(i)) begin
        q_nxt[i] = res1;
      end
    end
    q_cnt_nxt = base_idx + (adv ? n_res : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
    for (int i = 0; i < jbt_pkg::QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_valid         = q_cnt_r != 2'd0;
  assign out_tok_kind      = q_r[0].tok_kind;
  assign out_data_valid    = q_r[0].data_valid;
  assign out_data_byte_res = q_r[0].data_byte;
  assign out_token_end     = q_r[0].token_end;
  assign out_error_code    = q_r[0].error_code;
  assign out_last          = q_r[0].last;

`include "json_byte_tokenizer_top_assert.svh"

  `JBT_ASSERT(a_lit_pos,
    mode_r != jbt_pkg::MODE_LITERAL || (pos_r >= 3'd1 && pos_r <= 3'd4),
    "literal position out of range")
  `JBT_ASSERT(a_content,
    !(out_valid && out_data_valid) || (!out_token_end && out_error_code == jbt_pkg::ERR_NONE),
    "content byte carries end or error")
  `JBT_ASSERT_NEXT(a_q_full, q_cnt_r == 2'd0, q_cnt_r <= 2'd2,
    "queue filled past two from empty")

endmodule
